@@ rtl/arfp_pkg.sv @@
// ----------------------------------------------------------------------------
// arfp_pkg
// Shared types and constants for the alarm report frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package arfp_pkg;

  localparam int MaxFrameBytesDefault  = 1022;
  localparam int MaxRegionBytesDefault = 23;

  localparam logic [63:0] START_SEQ   = 64'h1B40_1B63_001B_3804;
  localparam logic [63:0] KEY_FIRE    = 64'hBBF0_A1A1_A1A1_BEAF;
  localparam logic [63:0] KEY_RECOVER = 64'hB9CA_D5CF_BBD6_B8B4;
  localparam logic [63:0] KEY_LOST    = 64'hB6AA_A1A1_A1A1_CAA7;
  localparam logic [31:0] END_SEQ     = 32'h0D0D_200D;
  localparam logic [15:0] AREA_MARK   = 16'hBBFA;
  localparam logic [15:0] NUM_MARK    = 16'hBAC5;
  localparam logic [7:0]  DASH        = 8'h2D;
  localparam logic [7:0]  DIGIT_ZERO  = 8'h30;

  localparam int NUM_TOKENS = 3;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_FIRE    = 2'd1,
    EV_RECOVER = 2'd2,
    EV_LOST    = 2'd3
  } event_t;

  typedef struct packed {
    event_t      event_code;
    logic [15:0] system_number;
    logic [15:0] host_number;
    logic [15:0] loop_number;
    logic [15:0] point_number;
  } report_t;

endpackage

`default_nettype wire

@@ rtl/arfp_core.sv @@
// ----------------------------------------------------------------------------
// arfp_core
// Frame state: start hunt, keyword flags, region number parse, end and length-limit detect.
// ----------------------------------------------------------------------------
`default_nettype none

module arfp_core #(
  parameter int MAX_FRAME_BYTES  = arfp_pkg::MaxFrameBytesDefault,
  parameter int MAX_REGION_BYTES = arfp_pkg::MaxRegionBytesDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        byte_in,
  input  wire logic [15:0]       system_id,
  output logic                   rpt_valid,
  output arfp_pkg::report_t      rpt
);

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int RC_W  = $clog2(MAX_REGION_BYTES + 1);

  logic              hunting, hunting_next;
  logic [LEN_W-1:0]  frame_length, frame_length_next;
  logic [63:0]       byte_window, byte_window_next;
  logic [2:0]        keyword_flags, keyword_flags_next;
  logic              rs_area, rs_area_next;
  logic              rs_closed, rs_closed_next;
  logic              rs_pending, rs_pending_next;
  logic [1:0]        token_index, token_index_next;
  logic              in_token, in_token_next;
  logic [RC_W-1:0]   region_count, region_count_next;
  logic [15:0]       acc [arfp_pkg::NUM_TOKENS];
  logic [15:0]       acc_next [arfp_pkg::NUM_TOKENS];

  logic [63:0]       win;
  logic [7:0]        rb;
  logic              clear;
  logic              valid_region;
  arfp_pkg::event_t  code;

  always_comb begin
    win                = {byte_window[55:0], byte_in};
    rb                 = win[15:8];
    hunting_next       = hunting;
    frame_length_next  = frame_length;
    byte_window_next   = byte_window;
    keyword_flags_next = keyword_flags;
    rs_area_next       = rs_area;
    rs_closed_next     = rs_closed;
    rs_pending_next    = rs_pending;
    token_index_next   = token_index;
    in_token_next      = in_token;
    region_count_next  = region_count;
    for (int i = 0; i < arfp_pkg::NUM_TOKENS; i++) acc_next[i] = acc[i];
    clear        = 1'b0;
    rpt_valid    = 1'b0;
    valid_region = 1'b0;
    code         = arfp_pkg::EV_NONE;

    if (step) begin
      byte_window_next = win;
      if (hunting) begin
        if (win == arfp_pkg::START_SEQ) begin
          hunting_next      = 1'b0;
          frame_length_next = LEN_W'(8);
        end
      end else begin
        frame_length_next = frame_length + LEN_W'(1);
        if (win == arfp_pkg::KEY_FIRE)    keyword_flags_next[0] = 1'b1;
        if (win == arfp_pkg::KEY_RECOVER) keyword_flags_next[1] = 1'b1;
        if (win == arfp_pkg::KEY_LOST)    keyword_flags_next[2] = 1'b1;

        if (!rs_closed) begin
          if (win[15:0] == arfp_pkg::NUM_MARK) begin
            rs_closed_next  = 1'b1;
            rs_pending_next = 1'b0;
          end else if (rs_area) begin
            // previous byte is a region byte once a newer one shows it is no marker
            if (rs_pending && region_count < RC_W'(MAX_REGION_BYTES)) begin
              if (rb == 8'h00) begin
                region_count_next = RC_W'(MAX_REGION_BYTES);
              end else begin
                region_count_next = region_count + RC_W'(1);
                if (rb == arfp_pkg::DASH) begin
                  if (in_token) begin
                    in_token_next = 1'b0;
                    if (token_index < 2'd3) token_index_next = token_index + 2'd1;
                  end
                end else begin
                  in_token_next = 1'b1;
                  if (token_index < 2'd3) begin
                    acc_next[token_index] = {acc[token_index][12:0], 3'b000}
                                          + {acc[token_index][14:0], 1'b0}
                                          + {8'h00, rb}
                                          - {8'h00, arfp_pkg::DIGIT_ZERO};
                  end
                end
              end
            end
            rs_pending_next = 1'b1;
          end else if (win[15:0] == arfp_pkg::AREA_MARK) begin
            rs_area_next = 1'b1;
          end
        end

        if (win[31:0] == arfp_pkg::END_SEQ) begin
          rpt_valid = 1'b1;
          clear     = 1'b1;
        end else if (frame_length_next >= LEN_W'(MAX_FRAME_BYTES)) begin
          clear = 1'b1;
        end
      end
    end

    valid_region = rs_area_next && rs_closed_next;
    if (keyword_flags_next[0])      code = arfp_pkg::EV_FIRE;
    else if (keyword_flags_next[1]) code = arfp_pkg::EV_RECOVER;
    else if (keyword_flags_next[2]) code = arfp_pkg::EV_LOST;

    rpt.event_code    = code;
    rpt.system_number = system_id;
    rpt.host_number   = valid_region ? acc_next[0] : 16'h0000;
    rpt.loop_number   = valid_region ? acc_next[1] : 16'h0000;
    rpt.point_number  = valid_region ? acc_next[2] : 16'h0000;

    if (clear) begin
      hunting_next       = 1'b1;
      frame_length_next  = '0;
      byte_window_next   = '0;
      keyword_flags_next = '0;
      rs_area_next       = 1'b0;
      rs_closed_next     = 1'b0;
      rs_pending_next    = 1'b0;
      token_index_next   = '0;
      in_token_next      = 1'b0;
      region_count_next  = '0;
      for (int i = 0; i < arfp_pkg::NUM_TOKENS; i++) acc_next[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting       <= 1'b1;
      frame_length  <= '0;
      byte_window   <= '0;
      keyword_flags <= '0;
      rs_area       <= 1'b0;
      rs_closed     <= 1'b0;
      rs_pending    <= 1'b0;
      token_index   <= '0;
      in_token      <= 1'b0;
      region_count  <= '0;
      for (int i = 0; i < arfp_pkg::NUM_TOKENS; i++) acc[i] <= '0;
    end else begin
      hunting       <= hunting_next;
      frame_length  <= frame_length_next;
      byte_window   <= byte_window_next;
      keyword_flags <= keyword_flags_next;
      rs_area       <= rs_area_next;
      rs_closed     <= rs_closed_next;
      rs_pending    <= rs_pending_next;
      token_index   <= token_index_next;
      in_token      <= in_token_next;
      region_count  <= region_count_next;
      for (int i = 0; i < arfp_pkg::NUM_TOKENS; i++) acc[i] <= acc_next[i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/arfp_out_queue.sv @@
// ----------------------------------------------------------------------------
// arfp_out_queue
// Two-entry report queue between the parser and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module arfp_out_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire arfp_pkg::report_t  push_rpt,
  input  wire logic               pop,
  output logic                    head_valid,
  output arfp_pkg::report_t       head_rpt,
  output logic [1:0]              count
);

  arfp_pkg::report_t mem [2];
  logic              wr_ptr;
  logic              rd_ptr;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_rpt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head_valid = (count != 2'd0);
  assign head_rpt   = mem[rd_ptr];

endmodule

`default_nettype wire

@@ rtl/alarm_report_frame_parser.sv @@
// Timing: a byte is registered on accept and parsed once the report queue has room;
//   the report for the closing byte is pushed into the queue and read from its register.
// Throughput: one byte per cycle; bytes keep flowing while one report waits,
//   and the input stalls only when the two-entry report queue is full.
// Reset: synchronous, active high; hunting for a start sequence, system_id 0.
// ----------------------------------------------------------------------------
// alarm_report_frame_parser
// Byte-serial alarm frame parser with a registered input and report queue.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_report_frame_parser #(
  parameter int MAX_FRAME_BYTES  = arfp_pkg::MaxFrameBytesDefault,
  parameter int MAX_REGION_BYTES = arfp_pkg::MaxRegionBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_code,
  output logic [15:0]      system_number,
  output logic [15:0]      host_number,
  output logic [15:0]      loop_number,
  output logic [15:0]      point_number
);

  logic              [15:0] system_id;
  logic                     stage_v;
  logic              [7:0]  stage_byte;
  logic                     step;
  logic                     pop;
  logic                     rpt_valid;
  arfp_pkg::report_t        rpt;
  arfp_pkg::report_t        head_rpt;
  logic              [1:0]  q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      system_id <= 16'h0000;
    end else if (cfg_valid) begin
      system_id <= cfg_data;
    end
  end

  assign pop      = out_valid && out_ready;
  // parse only when the queue can absorb a report this cycle
  assign step     = stage_v && ((q_count != 2'd2) || pop);
  assign in_ready = !stage_v || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_v <= 1'b1;
    end else if (step) begin
      stage_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stage_byte <= data_byte;
  end

  arfp_core #(
    .MAX_FRAME_BYTES  (MAX_FRAME_BYTES),
    .MAX_REGION_BYTES (MAX_REGION_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (stage_byte),
    .system_id (system_id),
    .rpt_valid (rpt_valid),
    .rpt       (rpt)
  );

  arfp_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (rpt_valid),
    .push_rpt   (rpt),
    .pop        (pop),
    .head_valid (out_valid),
    .head_rpt   (head_rpt),
    .count      (q_count)
  );

  assign event_code    = head_rpt.event_code;
  assign system_number = head_rpt.system_number;
  assign host_number   = head_rpt.host_number;
  assign loop_number   = head_rpt.loop_number;
  assign point_number  = head_rpt.point_number;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> (q_count != 2'd2 || pop))
    else $error("report pushed into a full queue");

  a_report_needs_step: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> step)
    else $error("report without a parsed byte");

  a_stage_loaded: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> stage_v)
    else $error("accepted request not held in input stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_v && !step) |=> (stage_v && $stable(stage_byte)))
    else $error("stalled byte lost from input stage");

endmodule

`default_nettype wire

@@ tb/alarm_report_frame_parser_tb.sv @@
// ----------------------------------------------------------------------------
// alarm_report_frame_parser_tb
// Streams alarm frames byte by byte into the parser, predicts each event report
// from the frame table or a behavioral model kept inside the bench, and checks
// every report against it. A directed table of frames comes first, then random
// frames with noise, broken sequences, new system ids. Both sides stall at random.
// ----------------------------------------------------------------------------
module alarm_report_frame_parser_tb;

  localparam int MAX_FRAME   = arfp_pkg::MaxFrameBytesDefault;
  localparam int MAX_AREA    = arfp_pkg::MaxRegionBytesDefault;
  localparam int N_ROWS      = 20;
  localparam int RAND_BYTES  = 360;
  localparam int RAND_PHASES = 6;
  localparam int RAND_REPORTS = 10;
  localparam int SETTLE      = 6;     // parser pipeline plus margin
  localparam int TAIL        = 16;
  localparam int QUIET_LIMIT = 2000;

  localparam logic [7:0] FILL = 8'hFF;

  // keyword masks for the frame table
  localparam logic [2:0] HAS_NONE    = 3'b000;
  localparam logic [2:0] HAS_FIRE    = 3'b001;
  localparam logic [2:0] HAS_RECOVER = 3'b010;
  localparam logic [2:0] HAS_LOST    = 3'b100;

  typedef enum int {
    SHAPE_NORMAL,     // area marker, numbers, number marker
    SHAPE_NO_AREA,
    SHAPE_NUM_FIRST,  // number marker ahead of the area marker
    SHAPE_NO_NUM,
    SHAPE_DROP        // runs past the length limit inside a start sequence
  } shape_t;

  // In area_text a '#' stands for a zero byte.
  typedef struct {
    logic [2:0]       keys;
    shape_t           shape;
    string            area_text;
    int               total_len;
    bit               typed;
    arfp_pkg::event_t ev;
    logic [15:0]      host_n;
    logic [15:0]      loop_n;
    logic [15:0]      point_n;
    int               sys_write;   // -1: leave system id alone
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  event_code;
  logic [15:0] system_number;
  logic [15:0] host_number;
  logic [15:0] loop_number;
  logic [15:0] point_number;

  alarm_report_frame_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME),
    .MAX_REGION_BYTES(MAX_AREA)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_code   (event_code),
    .system_number(system_number),
    .host_number  (host_number),
    .loop_number  (loop_number),
    .point_number (point_number)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // -------- parser model state --------
  logic [15:0] sys_id;
  bit          seek_start;
  int          frame_len;
  logic [63:0] window;
  logic [2:0]  keys_seen;
  bit          area_seen;
  bit          area_closed;
  bit          byte_held;
  int          field_idx;
  bit          in_field;
  int          area_count;
  logic [15:0] field_val [arfp_pkg::NUM_TOKENS];

  arfp_pkg::report_t awaited_reports [$];
  logic [7:0]        frame_bytes [$];
  frame_row_t        dir_rows [N_ROWS];

  arfp_pkg::report_t table_report;
  bit          table_armed = 1'b0;
  bit          idle_on = 1'b0;
  int          bytes_sent = 0;
  int          reports_due = 0;
  int          bad_reports = 0;
  int          stall_left = 0;

  function automatic void clear_frame();
    seek_start  = 1'b1;
    frame_len   = 0;
    window      = '0;
    keys_seen   = '0;
    area_seen   = 1'b0;
    area_closed = 1'b0;
    byte_held   = 1'b0;
    field_idx   = 0;
    in_field    = 1'b0;
    area_count  = 0;
    for (int i = 0; i < arfp_pkg::NUM_TOKENS; i++) field_val[i] = '0;
  endfunction

  // Advances the model by one byte; returns 1 with the report when a frame closes.
  function automatic bit step_parser(input logic [7:0] b, output arfp_pkg::report_t rep);
    logic [7:0] prev;
    rep = '0;
    window = {window[55:0], b};
    if (seek_start) begin
      if (window == arfp_pkg::START_SEQ) begin
        seek_start = 1'b0;
        frame_len = 8;
      end
      return 1'b0;
    end
    frame_len++;
    if (window == arfp_pkg::KEY_FIRE) keys_seen[0] = 1'b1;
    if (window == arfp_pkg::KEY_RECOVER) keys_seen[1] = 1'b1;
    if (window == arfp_pkg::KEY_LOST) keys_seen[2] = 1'b1;

    if (!area_closed) begin
      if (window[15:0] == arfp_pkg::NUM_MARK) begin
        area_closed = 1'b1;
        byte_held = 1'b0;
      end else if (area_seen) begin
        // the byte before this one is known not to start the number marker
        if (byte_held && area_count < MAX_AREA) begin
          prev = window[15:8];
          if (prev == 8'h00) begin
            area_count = MAX_AREA;
          end else begin
            area_count++;
            if (prev == arfp_pkg::DASH) begin
              if (in_field) begin
                in_field = 1'b0;
                if (field_idx < arfp_pkg::NUM_TOKENS) field_idx++;
              end
            end else begin
              in_field = 1'b1;
              if (field_idx < arfp_pkg::NUM_TOKENS)
                field_val[field_idx] = field_val[field_idx] * 16'd10 + {8'h00, prev}
                                       - {8'h00, arfp_pkg::DIGIT_ZERO};
            end
          end
        end
        byte_held = 1'b1;
      end else if (window[15:0] == arfp_pkg::AREA_MARK) begin
        area_seen = 1'b1;
      end
    end

    if (window[31:0] == arfp_pkg::END_SEQ) begin
      if (keys_seen[0]) rep.event_code = arfp_pkg::EV_FIRE;
      else if (keys_seen[1]) rep.event_code = arfp_pkg::EV_RECOVER;
      else if (keys_seen[2]) rep.event_code = arfp_pkg::EV_LOST;
      else rep.event_code = arfp_pkg::EV_NONE;
      rep.system_number = sys_id;
      if (area_seen && area_closed) begin
        rep.host_number  = field_val[0];
        rep.loop_number  = field_val[1];
        rep.point_number = field_val[2];
      end
      clear_frame();
      return 1'b1;
    end
    if (frame_len >= MAX_FRAME) clear_frame();
    return 1'b0;
  endfunction

  // -------- frame construction --------
  function automatic void add_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endfunction

  function automatic void push_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      add_byte((s[i] == "#") ? 8'h00 : s[i]);
  endfunction

  function automatic void build_frame(input frame_row_t r);
    frame_bytes.delete();
    push_be(arfp_pkg::START_SEQ, 8);
    push_be(64'({FILL, FILL}), 2);
    if (r.keys[0]) begin push_be(arfp_pkg::KEY_FIRE, 8); add_byte(FILL); end
    if (r.keys[1]) begin push_be(arfp_pkg::KEY_RECOVER, 8); add_byte(FILL); end
    if (r.keys[2]) begin push_be(arfp_pkg::KEY_LOST, 8); add_byte(FILL); end
    case (r.shape)
      SHAPE_NO_AREA: begin
        push_text(r.area_text);
        push_be(64'(arfp_pkg::NUM_MARK), 2);
      end
      SHAPE_NUM_FIRST: begin
        push_be(64'(arfp_pkg::NUM_MARK), 2);
        push_be(64'(arfp_pkg::AREA_MARK), 2);
        push_text(r.area_text);
        push_be(64'(arfp_pkg::NUM_MARK), 2);
      end
      SHAPE_NO_NUM: begin
        push_be(64'(arfp_pkg::AREA_MARK), 2);
        push_text(r.area_text);
      end
      SHAPE_DROP: begin
        // the limit falls after the first half of a new start sequence
        while (frame_bytes.size() < MAX_FRAME - 4) add_byte(FILL);
        push_be(arfp_pkg::START_SEQ, 8);
        push_be(64'(arfp_pkg::AREA_MARK), 2);
        push_text(r.area_text);
        push_be(64'(arfp_pkg::NUM_MARK), 2);
      end
      default: begin
        push_be(64'(arfp_pkg::AREA_MARK), 2);
        push_text(r.area_text);
        push_be(64'(arfp_pkg::NUM_MARK), 2);
      end
    endcase
    if (r.total_len > 0)
      while (frame_bytes.size() < r.total_len - 4) add_byte(FILL);
    push_be(64'(arfp_pkg::END_SEQ), 4);
  endfunction

  function automatic void random_area();
    int n, r;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 12);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 60) add_byte(arfp_pkg::DIGIT_ZERO + 8'($urandom_range(0, 9)));
      else if (r < 85) add_byte(arfp_pkg::DASH);
      else if (r < 97) add_byte(8'($urandom));
      else add_byte(8'h00);
    end
  endfunction

  function automatic void random_keyword();
    case ($urandom_range(0, 2))
      0: push_be(arfp_pkg::KEY_FIRE, 8);
      1: push_be(arfp_pkg::KEY_RECOVER, 8);
      default: push_be(arfp_pkg::KEY_LOST, 8);
    endcase
  endfunction

  function automatic void random_frame();
    int k;
    frame_bytes.delete();
    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      k = $urandom_range(1, 7);
      push_be(arfp_pkg::START_SEQ >> (8 * (8 - k)), k);
    end
    push_be(arfp_pkg::START_SEQ, 8);
    repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1) == 0) random_keyword();
      repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
    end
    case ($urandom_range(0, 11))
      0: begin
        random_area();
        push_be(64'(arfp_pkg::NUM_MARK), 2);
      end
      1: begin
        push_be(64'(arfp_pkg::NUM_MARK), 2);
        push_be(64'(arfp_pkg::AREA_MARK), 2);
        random_area();
        push_be(64'(arfp_pkg::NUM_MARK), 2);
      end
      2: begin
        push_be(64'(arfp_pkg::AREA_MARK), 2);
        random_area();
      end
      3: repeat ($urandom_range(0, 24)) add_byte(8'($urandom));
      4: begin
        push_be(64'(arfp_pkg::AREA_MARK), 2);
        push_be(64'(arfp_pkg::NUM_MARK), 2);
        push_be(64'(arfp_pkg::AREA_MARK), 2);
        random_area();
        push_be(64'(arfp_pkg::NUM_MARK), 2);
      end
      default: begin
        push_be(64'(arfp_pkg::AREA_MARK), 2);
        random_area();
        push_be(64'(arfp_pkg::NUM_MARK), 2);
      end
    endcase
    if ($urandom_range(0, 7) == 0) random_keyword();
    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      push_be(64'(arfp_pkg::END_SEQ >> 8), 3);      // end sequence cut short
      add_byte(8'h41);
    end
    push_be(64'(arfp_pkg::END_SEQ), 4);
  endfunction

  // -------- request drivers --------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    arfp_pkg::report_t rep;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (step_parser(b, rep)) begin
      if (table_armed) begin
        awaited_reports.insert(awaited_reports.size(), table_report);
        table_armed = 1'b0;
      end else begin
        awaited_reports.insert(awaited_reports.size(), rep);
      end
      reports_due++;
    end
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  task automatic stop_bytes();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_system_id(input logic [15:0] v);
    stop_bytes();
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sys_id = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // -------- report side --------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    arfp_pkg::report_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        bad_reports++;
        if (bad_reports <= 10)
          $display("unexpected report: ev %0d sys %h host %0d loop %0d point %0d",
                   event_code, system_number, host_number, loop_number, point_number);
      end else begin
        want = awaited_reports.pop_front();
        if (event_code !== want.event_code || system_number !== want.system_number ||
            host_number !== want.host_number || loop_number !== want.loop_number ||
            point_number !== want.point_number) begin
          bad_reports++;
          if (bad_reports <= 10)
            $display({"report mismatch: want ev %0d sys %h host %0d loop %0d point %0d",
                      " / got ev %0d sys %h host %0d loop %0d point %0d"},
                     want.event_code, want.system_number, want.host_number,
                     want.loop_number, want.point_number, event_code, system_number,
                     host_number, loop_number, point_number);
        end
      end
    end
  end

  // ends the run when no request moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // -------- stimulus --------
  initial begin
    int phase_end;
    int rand_base;
    logic [15:0] id;

    dir_rows = '{
      '{HAS_NONE, SHAPE_NORMAL, "12-34-56", 0, 1'b1, arfp_pkg::EV_NONE,
        16'd12, 16'd34, 16'd56, 0},
      '{HAS_FIRE, SHAPE_NORMAL, "1-2-3", 0, 1'b1, arfp_pkg::EV_FIRE,
        16'd1, 16'd2, 16'd3, -1},
      '{HAS_RECOVER, SHAPE_NORMAL, "65535-0-7", 0, 1'b1, arfp_pkg::EV_RECOVER,
        16'd65535, 16'd0, 16'd7, -1},
      '{HAS_LOST, SHAPE_NORMAL, "0-0-0", 0, 1'b1, arfp_pkg::EV_LOST,
        16'd0, 16'd0, 16'd0, -1},
      '{HAS_FIRE | HAS_RECOVER | HAS_LOST, SHAPE_NORMAL, "9-8-7", 0, 1'b1,
        arfp_pkg::EV_FIRE, 16'd9, 16'd8, 16'd7, -1},
      '{HAS_RECOVER | HAS_LOST, SHAPE_NORMAL, "5", 0, 1'b1, arfp_pkg::EV_RECOVER,
        16'd5, 16'd0, 16'd0, -1},
      '{HAS_FIRE | HAS_LOST, SHAPE_NORMAL, "42", 0, 1'b1, arfp_pkg::EV_FIRE,
        16'd42, 16'd0, 16'd0, -1},
      // values wrap modulo 65536
      '{HAS_NONE, SHAPE_NORMAL, "65536-70000-99999", 0, 1'b1, arfp_pkg::EV_NONE,
        16'd0, 16'd4464, 16'd34463, -1},
      '{HAS_NONE, SHAPE_NORMAL, "--12---34--56--", 0, 1'b1, arfp_pkg::EV_NONE,
        16'd12, 16'd34, 16'd56, 65535},
      '{HAS_LOST, SHAPE_NORMAL, "1-2-3-4-5", 0, 1'b1, arfp_pkg::EV_LOST,
        16'd1, 16'd2, 16'd3, -1},
      '{HAS_NONE, SHAPE_NORMAL, "12-3A-5", 0, 1'b0, arfp_pkg::EV_NONE,
        '0, '0, '0, -1},
      '{HAS_NONE, SHAPE_NORMAL, "12345678901234567890-77-8", 0, 1'b0, arfp_pkg::EV_NONE,
        '0, '0, '0, -1},
      '{HAS_FIRE, SHAPE_NORMAL, "12-3#4-5", 0, 1'b1, arfp_pkg::EV_FIRE,
        16'd12, 16'd3, 16'd0, -1},
      '{HAS_NONE, SHAPE_NO_AREA, "1-2-3", 0, 1'b1, arfp_pkg::EV_NONE,
        16'd0, 16'd0, 16'd0, -1},
      '{HAS_RECOVER, SHAPE_NUM_FIRST, "4-5-6", 0, 1'b1, arfp_pkg::EV_RECOVER,
        16'd0, 16'd0, 16'd0, -1},
      '{HAS_LOST, SHAPE_NO_NUM, "7-8-9", 0, 1'b1, arfp_pkg::EV_LOST,
        16'd0, 16'd0, 16'd0, -1},
      '{HAS_NONE, SHAPE_NORMAL, "", 0, 1'b1, arfp_pkg::EV_NONE,
        16'd0, 16'd0, 16'd0, -1},
      // ends on the very last byte allowed
      '{HAS_FIRE, SHAPE_NORMAL, "4-5-6", MAX_FRAME, 1'b1, arfp_pkg::EV_FIRE,
        16'd4, 16'd5, 16'd6, -1},
      '{HAS_NONE, SHAPE_DROP, "1-2-3", 0, 1'b0, arfp_pkg::EV_NONE,
        '0, '0, '0, -1},
      '{HAS_NONE, SHAPE_NORMAL, "255-128-1", 0, 1'b1, arfp_pkg::EV_NONE,
        16'd255, 16'd128, 16'd1, -1}
    };

    sys_id = '0;
    clear_frame();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    idle_on = 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].sys_write >= 0) write_system_id(dir_rows[i].sys_write[15:0]);
      build_frame(dir_rows[i]);
      table_armed = dir_rows[i].typed;
      table_report = '{dir_rows[i].ev, sys_id, dir_rows[i].host_n,
                       dir_rows[i].loop_n, dir_rows[i].point_n};
      send_frame();
      table_armed = 1'b0;
    end

    rand_base = reports_due;
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 1) id = 16'hFFFF;
      else if (p == 2) id = 16'h0000;
      else id = 16'($urandom);
      write_system_id(id);
      idle_on = (p == RAND_PHASES - 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
      phase_end = bytes_sent + RAND_BYTES / RAND_PHASES;
      while (bytes_sent < phase_end ||
             (p == RAND_PHASES - 1 && reports_due - rand_base < RAND_REPORTS)) begin
        random_frame();
        send_frame();
      end
    end

    stop_bytes();
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (bad_reports == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
